[rtl/core/scdp_pkg.sv]
// Shared types and constants of the sum constraint domain propagator.
// No dependencies; the channel interfaces and the top level import it.
package scdp_pkg;

  // Widths of the payload fields.
  localparam int unsigned DomW   = 64;
  localparam int unsigned CvW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // Operation codes.
  localparam logic OP_NARROW = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Changed-variable codes.
  localparam logic [CvW-1:0] CV_SUM   = 2'd0;
  localparam logic [CvW-1:0] CV_TERM1 = 2'd1;
  localparam logic [CvW-1:0] CV_TERM2 = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MIN_VALUE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DOMAIN_SIZE = 1'b1;

  // Domain updated by one combine pass.
  typedef enum logic [1:0] {
    TGT_SUM   = 2'd0,
    TGT_TERM1 = 2'd1,
    TGT_TERM2 = 2'd2
  } tgt_e;

  // Target of a given pass for an operation and changed variable.
  function automatic tgt_e pass_tgt(logic op, logic [CvW-1:0] cv, logic [1:0] pass);
    tgt_e t;
    t = TGT_SUM;
    if (op == OP_CHECK) begin
      unique case (pass)
        2'd0:    t = TGT_SUM;
        2'd1:    t = TGT_TERM1;
        default: t = TGT_TERM2;
      endcase
    end else begin
      unique case (cv)
        CV_SUM:   t = (pass == 2'd0) ? TGT_TERM1 : TGT_TERM2;
        CV_TERM1: t = (pass == 2'd0) ? TGT_SUM : TGT_TERM2;
        default:  t = (pass == 2'd0) ? TGT_SUM : TGT_TERM1;
      endcase
    end
    return t;
  endfunction

  // True on the final pass of an operation.
  function automatic logic pass_last(logic op, logic [1:0] pass);
    return (op == OP_CHECK) ? (pass == 2'd2) : (pass == 2'd1);
  endfunction

endpackage

[rtl/core/scdp_in_if.sv]
// Input channel of the propagator: valid, ready and one input word.
// Depends on scdp_pkg for the field widths.
interface scdp_in_if;
  import scdp_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CvW-1:0]  changed_var;
  logic [DomW-1:0] sum_domain;
  logic [DomW-1:0] first_term_domain;
  logic [DomW-1:0] second_term_domain;

  modport source (
    output valid, opcode, changed_var, sum_domain, first_term_domain, second_term_domain,
    input  ready
  );
  modport sink (
    input  valid, opcode, changed_var, sum_domain, first_term_domain, second_term_domain,
    output ready
  );
endinterface

[rtl/core/scdp_out_if.sv]
// Output channel of the propagator: valid, ready and one result word.
// Depends on scdp_pkg for the field widths.
interface scdp_out_if;
  import scdp_pkg::*;

  logic            valid;
  logic            ready;
  logic [DomW-1:0] new_sum_domain;
  logic [DomW-1:0] new_first_term_domain;
  logic [DomW-1:0] new_second_term_domain;
  logic            failed;
  logic            conflict;

  modport source (
    output valid, new_sum_domain, new_first_term_domain, new_second_term_domain,
           failed, conflict,
    input  ready
  );
  modport sink (
    input  valid, new_sum_domain, new_first_term_domain, new_second_term_domain,
           failed, conflict,
    output ready
  );
endinterface

[rtl/core/sum_constraint_domain_propagator.sv]
// Sum constraint propagator: narrows or checks sum = term1 + term2 over bitset domains.
// Operation: one shared shifter walks one bit of a domain per cycle, over DOMAIN_BITS bits a pass;
// narrow runs 2 passes, check 3, both stop after the pass that empties a domain, and a narrow
// with an unknown changed variable runs no pass. The result word is held in an output register.
// A new input word is taken only once the last result is loaded, which waits on a full output.
// Reset (rst_ni, async low) clears control state, min_value to 0 and domain_size to 64.
module sum_constraint_domain_propagator #(
  parameter int unsigned DOMAIN_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scdp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [scdp_pkg::CfgDataW-1:0]   cfg_data_i,
  scdp_in_if.sink                         in_chan_i,
  scdp_out_if.source                      out_chan_o
);
  import scdp_pkg::*;

  localparam int unsigned IW = (DOMAIN_BITS > 1) ? $clog2(DOMAIN_BITS) : 1;
  localparam int unsigned SzW = 7;
  localparam int unsigned KW = 35;
  localparam logic [IW-1:0] ILast = IW'(DOMAIN_BITS - 1);
  localparam logic signed [KW-1:0] KMax = KW'(DOMAIN_BITS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // Configuration registers.
  logic signed [CfgDataW-1:0] min_value_q;
  logic [SzW-1:0]             domain_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q   <= '0;
      domain_size_q <= SzW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_VALUE:   min_value_q   <= cfg_data_i;
        REG_DOMAIN_SIZE: domain_size_q <= cfg_data_i[SzW-1:0];
        default:         ;
      endcase
    end
  end

  // Valid-bit mask: bit b is inside the domain when b < domain_size.
  logic [DOMAIN_BITS-1:0] size_mask;
  always_comb begin
    for (int b = 0; b < DOMAIN_BITS; b++) begin
      size_mask[b] = (SzW'(b) < domain_size_q);
    end
  end

  // Sequencer and working registers.
  state_e                 state_q, state_d;
  logic                   op_q, op_d;
  logic [CvW-1:0]         cv_q, cv_d;
  logic [1:0]             pass_q, pass_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [DOMAIN_BITS-1:0] sum_q, sum_d;
  logic [DOMAIN_BITS-1:0] t1_q, t1_d;
  logic [DOMAIN_BITS-1:0] t2_q, t2_d;
  logic [DOMAIN_BITS-1:0] acc_q, acc_d;
  logic                   fail_q, fail_d;
  logic                   conf_q, conf_d;

  // Output register.
  logic                   out_vld_q, out_vld_d;
  logic [DOMAIN_BITS-1:0] out_sum_q, out_t1_q, out_t2_q;
  logic                   out_fail_q, out_conf_q;
  logic                   out_load;

  // Operand selection for the current pass.
  tgt_e                   tgt;
  logic                   is_add;
  logic [DOMAIN_BITS-1:0] walk_bits, shift_bits, tgt_bits;
  logic signed [KW-1:0]   k_raw, k;
  logic [KW-1:0]          k_abs;
  logic [DOMAIN_BITS-1:0] shifted;
  logic [DOMAIN_BITS-1:0] acc_next, res;

  always_comb begin
    tgt = pass_tgt(op_q, cv_q, pass_q);
    unique case (tgt)
      TGT_SUM: begin
        is_add = 1'b1;  walk_bits = t1_q; shift_bits = t2_q;  tgt_bits = sum_q;
      end
      TGT_TERM1: begin
        is_add = 1'b0;  walk_bits = t2_q; shift_bits = sum_q; tgt_bits = t1_q;
      end
      default: begin
        is_add = 1'b0;  walk_bits = t1_q; shift_bits = sum_q; tgt_bits = t2_q;
      end
    endcase
  end

  // Shared shifter: add moves term2 by i + min, subtract moves sum by -(j + min).
  always_comb begin
    k_raw = $signed({{(KW - IW){1'b0}}, idx_q})
          + $signed({{(KW - CfgDataW){min_value_q[CfgDataW-1]}}, min_value_q});
    k     = is_add ? k_raw : -k_raw;
    k_abs = k[KW-1] ? KW'(-k) : KW'(k);
    if (k >= KMax || k <= -KMax) begin
      shifted = '0;
    end else if (k[KW-1]) begin
      shifted = shift_bits >> k_abs[IW-1:0];
    end else begin
      shifted = shift_bits << k_abs[IW-1:0];
    end
    acc_next = walk_bits[idx_q] ? (acc_q | shifted) : acc_q;
    res      = tgt_bits & acc_next;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cv_d    = cv_q;
    pass_d  = pass_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    t1_d    = t1_q;
    t2_d    = t2_q;
    acc_d   = acc_q;
    fail_d  = fail_q;
    conf_d  = conf_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_chan_i.valid) begin
          op_d   = in_chan_i.opcode;
          cv_d   = in_chan_i.changed_var;
          sum_d  = in_chan_i.sum_domain[DOMAIN_BITS-1:0] & size_mask;
          t1_d   = in_chan_i.first_term_domain[DOMAIN_BITS-1:0] & size_mask;
          t2_d   = in_chan_i.second_term_domain[DOMAIN_BITS-1:0] & size_mask;
          pass_d = 2'd0;
          idx_d  = '0;
          acc_d  = '0;
          fail_d = 1'b0;
          conf_d = 1'b0;
          if (in_chan_i.opcode == OP_NARROW && in_chan_i.changed_var != CV_SUM &&
              in_chan_i.changed_var != CV_TERM1 && in_chan_i.changed_var != CV_TERM2) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        acc_d = acc_next;
        idx_d = idx_q + IW'(1);
        if (idx_q == ILast) begin
          // End of a pass: intersect with the target domain.
          idx_d = '0;
          acc_d = '0;
          if (op_q == OP_NARROW) begin
            unique case (tgt)
              TGT_SUM:   sum_d = res;
              TGT_TERM1: t1_d  = res;
              default:   t2_d  = res;
            endcase
          end
          if (res == '0) begin
            fail_d  = (op_q == OP_NARROW);
            conf_d  = (op_q == OP_CHECK);
            state_d = ST_FINISH;
          end else if (pass_last(op_q, pass_q)) begin
            state_d = ST_FINISH;
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || out_chan_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_chan_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pass_q    <= '0;
      idx_q     <= '0;
      fail_q    <= 1'b0;
      conf_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      idx_q     <= idx_d;
      fail_q    <= fail_d;
      conf_q    <= conf_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cv_q  <= cv_d;
    sum_q <= sum_d;
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    acc_q <= acc_d;
    if (out_load) begin
      out_sum_q  <= sum_q;
      out_t1_q   <= t1_q;
      out_t2_q   <= t2_q;
      out_fail_q <= fail_q;
      out_conf_q <= conf_q;
    end
  end

  // Ports.
  assign in_chan_i.ready                   = (state_q == ST_IDLE);
  assign out_chan_o.valid                  = out_vld_q;
  assign out_chan_o.new_sum_domain         = DomW'(out_sum_q);
  assign out_chan_o.new_first_term_domain  = DomW'(out_t1_q);
  assign out_chan_o.new_second_term_domain = DomW'(out_t2_q);
  assign out_chan_o.failed                 = out_fail_q;
  assign out_chan_o.conflict               = out_conf_q;

  // A result word never flags both a failure and a conflict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_fail_q && out_conf_q))
    else $error("failed and conflict set together");

  // A failed narrowing always leaves one domain empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_fail_q) |-> (out_sum_q == '0 || out_t1_q == '0 || out_t2_q == '0))
    else $error("failure reported with no empty domain");

  // The pass counter stays within the three passes of a check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pass_q != 2'd3 && (op_q == OP_CHECK || pass_q != 2'd2)))
    else $error("pass counter out of range");

endmodule
